/* src/pee_pkg.sv */
// shared types and constants of the prefix expression evaluator
`timescale 1ns / 1ps

package pee_pkg;

  localparam int unsigned DataW = 32;

  // character codes
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_UNDERFLOW = 3'd1,
    STATUS_OVERFLOW  = 3'd2,
    STATUS_DIVZERO   = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_e;

  // what each stack cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] result_value;
    status_e                 status;
  } out_item_t;

endpackage

/* src/prefix_expression_evaluator_core.sv */
// Prefix expression evaluator: characters arrive last to first, a stack of
// shifting cells holds the operands.
// Characters are taken one at a time in idle and worked in execute; multiply
// adds a state for the registered product, divide waits on the iterative
// divider (one quotient bit per cycle). Finish registers the final result.
// Reset empties the stack and clears the held error.
`timescale 1ns / 1ps

module prefix_expression_evaluator_core #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pee_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pee_pkg::out_item_t out_data_o
);
  import pee_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  status_e          err_q, err_d;
  logic [7:0]       char_q;
  logic             last_q;
  logic [DataW-1:0] prod_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q;

  logic [DataW-1:0] cell_data [STACK_DEPTH];
  cell_op_e         cell_op;
  logic [DataW-1:0] push_val;
  logic             in_ready;
  logic             out_load;
  logic             out_free;
  logic             div_start;
  logic             div_done;
  logic [DataW-1:0] div_quo;
  logic [DataW-1:0] top_a, top_b;
  logic             is_digit, is_op, enough, b_zero, stack_full;

  // operand views and character decode
  assign top_a      = cell_data[0];
  assign top_b      = cell_data[1];
  assign is_digit   = (char_q >= CharZero) && (char_q <= CharNine);
  assign is_op      = (char_q == CharPlus) || (char_q == CharMinus) ||
                      (char_q == CharStar) || (char_q == CharSlash);
  assign enough     = count_q >= CntW'(2);
  assign stack_full = count_q >= CntW'(STACK_DEPTH);
  assign b_zero     = top_b == '0;
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (is_op && enough && char_q == CharStar) begin
          state_d = ST_MUL;
        end else if (is_op && enough && char_q == CharSlash && !b_zero) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MUL: state_d = ST_FIN;
      ST_DIV: if (div_done) state_d = ST_FIN;
      ST_FIN: if (!last_q || out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // stack control, error tracking and result load
  always_comb begin
    in_ready  = 1'b0;
    cell_op   = CELL_HOLD;
    push_val  = '0;
    count_d   = count_q;
    err_d     = err_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: begin
        if (is_digit) begin
          if (!stack_full) begin
            cell_op  = CELL_PUSH;
            push_val = DataW'(char_q - CharZero);
            count_d  = count_q + CntW'(1);
          end else if (err_q == STATUS_OK) begin
            err_d = STATUS_OVERFLOW;
          end
        end else if (is_op) begin
          if (!enough) begin
            if (err_q == STATUS_OK) err_d = STATUS_UNDERFLOW;
          end else begin
            case (char_q)
              CharPlus: begin
                cell_op  = CELL_POP;
                push_val = top_a + top_b;
                count_d  = count_q - CntW'(1);
              end
              CharMinus: begin
                cell_op  = CELL_POP;
                push_val = top_a - top_b;
                count_d  = count_q - CntW'(1);
              end
              CharSlash: begin
                if (b_zero) begin
                  cell_op  = CELL_POP;
                  push_val = '0;
                  count_d  = count_q - CntW'(1);
                  if (err_q == STATUS_OK) err_d = STATUS_DIVZERO;
                end else begin
                  div_start = 1'b1;
                end
              end
              default: cell_op = CELL_HOLD;
            endcase
          end
        end
      end
      ST_MUL: begin
        cell_op  = CELL_POP;
        push_val = prod_q;
        count_d  = count_q - CntW'(1);
      end
      ST_DIV: begin
        if (div_done) begin
          cell_op  = CELL_POP;
          push_val = div_quo;
          count_d  = count_q - CntW'(1);
        end
      end
      ST_FIN: begin
        if (last_q && out_free) begin
          out_load = 1'b1;
          count_d  = '0;
          err_d    = STATUS_OK;
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  // output slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      err_q       <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      char_q <= in_data_i.char_code;
      last_q <= in_data_i.is_last;
    end
    if (state_q == ST_EXEC) begin
      prod_q <= top_a * top_b;
    end
    if (out_load) begin
      out_data_q.result_value <= (count_q != '0) ? $signed(top_a) : '0;
      if (err_q != STATUS_OK) begin
        out_data_q.status <= err_q;
      end else if (count_q == '0) begin
        out_data_q.status <= STATUS_EMPTY;
      end else begin
        out_data_q.status <= STATUS_OK;
      end
    end
  end

  // stack as a row of cells, top at index zero
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DataW-1:0] prev_val, next_val;
    if (i == 0) begin : g_top
      assign prev_val = push_val;
      assign next_val = push_val;
    end else if (i == STACK_DEPTH - 1) begin : g_bottom
      assign prev_val = cell_data[i-1];
      assign next_val = '0;
    end else begin : g_mid
      assign prev_val = cell_data[i-1];
      assign next_val = cell_data[i+1];
    end
    pee_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op),
      .prev_i (prev_val),
      .next_i (next_val),
      .data_o (cell_data[i])
    );
  end

  pee_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (top_a),
    .divisor_i  (top_b),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/pee_cell.sv */
// one stack entry: holds, takes the entry above it on push, or the one below on pop
`timescale 1ns / 1ps

module pee_cell (
  input  logic                     clk_i,
  input  pee_pkg::cell_op_e        op_i,
  input  logic [pee_pkg::DataW-1:0] prev_i,
  input  logic [pee_pkg::DataW-1:0] next_i,
  output logic [pee_pkg::DataW-1:0] data_o
);
  import pee_pkg::*;

  logic [DataW-1:0] data_q;

  // shift toward the bottom on push, toward the top on pop
  always_ff @(posedge clk_i) begin
    case (op_i)
      CELL_PUSH: data_q <= prev_i;
      CELL_POP:  data_q <= next_i;
      default:   data_q <= data_q;
    endcase
  end

  assign data_o = data_q;

endmodule

/* src/pee_divider.sv */
// iterative signed divider, one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps

module pee_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pee_pkg::DataW-1:0] dividend_i,
  input  logic [pee_pkg::DataW-1:0] divisor_i,
  output logic                      done_o,
  output logic [pee_pkg::DataW-1:0] quotient_o
);
  import pee_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] div_q, div_d;
  logic            neg_q, neg_d;
  logic [DataW:0]  rem_shift;
  logic [DataW:0]  rem_sub;

  assign rem_shift = {rem_q, quo_q[DataW-1]};
  assign rem_sub   = rem_shift - {1'b0, div_q};

  // restoring step and start of a new division
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DataW - 1);
      rem_d  = '0;
      quo_d  = dividend_i[DataW-1] ? (DataW'(0) - dividend_i) : dividend_i;
      div_d  = divisor_i[DataW-1] ? (DataW'(0) - divisor_i) : divisor_i;
      neg_d  = dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      if (!rem_sub[DataW]) begin
        rem_d = rem_sub[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DataW'(0) - quo_q) : quo_q;

endmodule

/* dv/tb.sv */
// self-checking testbench for the prefix expression evaluator core
`timescale 1ns / 1ps

module tb;
  import pee_pkg::*;

  localparam int unsigned StackDepth  = 64;
  localparam int unsigned NumDirected = 24;
  localparam int unsigned WorkTarget  = 850;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 80;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct packed {
    logic [7:0]  char_code;
    logic        is_last;
    logic        typed;
    logic [31:0] value;
    status_e     status;
  } step_row_t;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // evaluator state mirrored by the testbench
  logic [31:0]  calc_stack [StackDepth];
  int unsigned  calc_depth = 0;
  status_e      calc_err = STATUS_OK;

  out_item_t    pending_results [$];
  in_item_t     expr_chars [$];
  int unsigned  err_count = 0;
  int unsigned  work_items = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  stall_left = 0;
  bit           calm = 1'b0;

  logic [7:0] op_codes [4] = '{CharPlus, CharMinus, CharStar, CharSlash};

  step_row_t directed_steps [NumDirected] = '{
    '{"5",       1'b1, 1'b1, 32'd0 + 32'd5, STATUS_OK},
    '{CharPlus,  1'b1, 1'b1, 32'd0, STATUS_UNDERFLOW},
    '{"x",       1'b1, 1'b1, 32'd0, STATUS_EMPTY},
    '{"9",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{"0",       1'b1, 1'b1, 32'd0, STATUS_OK},
    '{"3",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{"4",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{CharMinus, 1'b1, 1'b0, 32'd0, STATUS_OK},
    '{"0",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{"7",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{CharSlash, 1'b1, 1'b1, 32'd0, STATUS_DIVZERO},
    '{"9",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{"9",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{CharStar,  1'b1, 1'b0, 32'd0, STATUS_OK},
    '{"2",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{"7",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{CharSlash, 1'b0, 1'b0, 32'd0, STATUS_OK},
    '{"0",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{CharMinus, 1'b1, 1'b0, 32'd0, STATUS_OK},
    '{"1",       1'b0, 1'b0, 32'd0, STATUS_OK},
    '{CharStar,  1'b0, 1'b0, 32'd0, STATUS_OK},
    '{"8",       1'b1, 1'b0, 32'd0, STATUS_OK},
    '{8'hFF,     1'b0, 1'b0, 32'd0, STATUS_OK},
    '{8'h00,     1'b1, 1'b1, 32'd0, STATUS_EMPTY}
  };

  prefix_expression_evaluator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // sticky error keeps the first one of the expression
  function automatic void note_error(status_e code);
    if (calc_err == STATUS_OK) calc_err = code;
  endfunction

  function automatic void push_operand(logic [31:0] v);
    if (calc_depth < StackDepth) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end else begin
      note_error(STATUS_OVERFLOW);
    end
  endfunction

  // evaluate one character; returns 1 when it closes an expression
  function automatic bit eval_char(in_item_t it, output out_item_t res);
    logic [31:0] a, b, r, ma, mb, q;
    res = '0;
    r = '0;
    if (it.char_code inside {CharPlus, CharMinus, CharStar, CharSlash}) begin
      if (calc_depth < 2) begin
        note_error(STATUS_UNDERFLOW);
      end else begin
        a = calc_stack[calc_depth-1];
        b = calc_stack[calc_depth-2];
        calc_depth -= 2;
        case (it.char_code)
          CharPlus:  r = a + b;
          CharMinus: r = a - b;
          CharStar:  r = a * b;
          default: begin
            if (b == '0) begin
              r = '0;
              note_error(STATUS_DIVZERO);
            end else begin
              // magnitudes, then sign; most negative over -1 wraps
              ma = a[31] ? 32'd0 - a : a;
              mb = b[31] ? 32'd0 - b : b;
              q  = ma / mb;
              r  = (a[31] ^ b[31]) ? 32'd0 - q : q;
            end
          end
        endcase
        push_operand(r);
      end
    end else if (it.char_code inside {[CharZero:CharNine]}) begin
      push_operand(32'(it.char_code - CharZero));
    end
    if (!it.is_last) return 1'b0;
    res.result_value = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
    if (calc_err != STATUS_OK) res.status = calc_err;
    else if (calc_depth == 0) res.status = STATUS_EMPTY;
    else res.status = STATUS_OK;
    calc_depth = 0;
    calc_err = STATUS_OK;
    return 1'b1;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // one input transfer; the expectation is recorded at acceptance
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    int unsigned gap;
    out_item_t   res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (it.is_last || it.char_code inside {CharPlus, CharMinus, CharStar, CharSlash,
                                           [CharZero:CharNine]})
      work_items++;
    if (eval_char(it, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'(CharZero + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_op();
    return op_codes[$urandom_range(0, 3)];
  endfunction

  // filler character that leaves the stack alone
  function automatic logic [7:0] rand_noise();
    logic [7:0] ch;
    ch = 8'($urandom_range(0, 255));
    if (ch inside {CharPlus, CharMinus, CharStar, CharSlash, [CharZero:CharNine]})
      ch = " ";
    return ch;
  endfunction

  task automatic add_char(logic [7:0] ch);
    in_item_t it;
    it.char_code = ch;
    it.is_last   = 1'b0;
    expr_chars.push_back(it);
  endtask

  // mark the final character and send the whole expression
  task automatic send_expr();
    if (expr_chars.size() == 0) add_char(rand_digit());
    expr_chars[expr_chars.size()-1].is_last = 1'b1;
    foreach (expr_chars[i]) send_item(expr_chars[i], 1'b0, '0);
    expr_chars.delete();
  endtask

  // valid expression; leaves pushed ahead of operators when deep is set
  task automatic build_expr(int unsigned leaves, bit deep, bit noisy);
    int unsigned pushed, depth;
    pushed = 0;
    depth = 0;
    while (pushed < leaves || depth > 1) begin
      if (noisy && $urandom_range(0, 99) < 8) add_char(rand_noise());
      if (pushed < leaves && (depth < 2 || deep || $urandom_range(0, 1) == 0)) begin
        add_char(rand_digit());
        pushed++;
        depth++;
      end else begin
        add_char(rand_op());
        depth--;
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    if (stall_left > 0 && !calm) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  // result checking
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                  out_data.result_value, out_data.status));
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value)
          report_mismatch($sformatf("result_value got %0d want %0d",
                                    out_data.result_value, want.result_value));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, want.status));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    in_item_t    it;
    out_item_t   typed_res;
    int unsigned kind;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NumDirected; i++) begin
      it.char_code = directed_steps[i].char_code;
      it.is_last   = directed_steps[i].is_last;
      typed_res.result_value = directed_steps[i].value;
      typed_res.status       = directed_steps[i].status;
      send_item(it, directed_steps[i].typed, typed_res);
    end

    // random expressions
    while (work_items < WorkTarget) begin
      calm = ($urandom_range(0, 99) < 15);
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        build_expr($urandom_range(1, 12), 1'b0, 1'b1);
        send_expr();
      end else if (kind < 71) begin
        build_expr($urandom_range(30, 64), 1'b1, 1'b0);
        send_expr();
      end else if (kind < 74) begin
        // pushes past a full stack, then a few operators
        repeat (StackDepth + $urandom_range(1, 3)) add_char(rand_digit());
        repeat ($urandom_range(0, 3)) add_char(rand_op());
        send_expr();
      end else if (kind < 77) begin
        // -1 below 2^31, then the wrapping division
        add_char("1");
        add_char("0");
        add_char(CharMinus);
        add_char("2");
        repeat (10) begin
          add_char("8");
          add_char(CharStar);
        end
        add_char(CharSlash);
        send_expr();
      end else if (kind < 90) begin
        // broken sequence: random mix of operands and operators
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 9) < 5) add_char(rand_digit());
          else if ($urandom_range(0, 4) != 0) add_char(rand_op());
          else add_char(rand_noise());
        end
        send_expr();
      end else begin
        // raw characters with a random last flag
        repeat ($urandom_range(1, 4)) begin
          it.char_code = 8'($urandom_range(0, 255));
          it.is_last   = 1'($urandom_range(0, 1));
          send_item(it, 1'b0, '0);
        end
      end
    end

    // drain
    calm = 1'b1;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pee_pkg.sv
src/pee_cell.sv
src/pee_divider.sv
src/prefix_expression_evaluator_core.sv
dv/tb.sv
